>>> rtl/core/ake_pkg.sv
// ake_pkg: shared types, codes and tables for the AES key schedule block.
// Holds the S-box, GF(2^8) doubling, FSM state type and byte-lane control.
// No dependencies.
package ake_pkg;

  localparam int MAX_WORDS_DEF = 64;
  localparam logic [3:0] NK_RESET = 4'd4;
  localparam logic [3:0] NK_MIN = 4'd4;
  localparam logic [3:0] NK_MAX = 4'd8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_NOKEY   = 2'd2,
    STAT_LOADIDX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_EXP_RD,
    ST_EXP_LOAD,
    ST_EXP_SHIFT,
    ST_EXP_WR
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic rot;
    logic sub;
    logic rcon_en;
  } lane_ctrl_t;

  localparam logic [7:0] SBOX_TABLE [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX_TABLE[a];
  endfunction

  // xtime in GF(2^8), polynomial 0x11b
  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

>>> rtl/core/ake_byte_lane.sv
// ake_byte_lane: byte-serial datapath for one new schedule word.
// Shifts w[k-1] a byte per cycle while ctrl.shift is set, through
// one S-box if ctrl.sub, XORing w[k-Nk] and rcon. Depends on ake_pkg.
module ake_byte_lane (
  input  logic                clk,
  input  ake_pkg::lane_ctrl_t ctrl,
  input  logic [31:0]         prev_word,
  input  logic [31:0]         back_word,
  input  logic [7:0]          rcon,
  output logic [31:0]         word_out
);
  import ake_pkg::*;

  logic [31:0] t_sr;
  logic [31:0] b_sr;
  logic [31:0] res_sr;
  logic [7:0]  r_byte;
  logic        sub_q;
  logic [7:0]  sub_byte;
  logic [7:0]  byte_out;

  always_comb begin
    sub_byte = sub_q ? sbox(t_sr[31:24]) : t_sr[31:24];
    byte_out = sub_byte ^ b_sr[31:24] ^ r_byte;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      t_sr   <= ctrl.rot ? {prev_word[23:0], prev_word[31:24]} : prev_word;
      b_sr   <= back_word;
      r_byte <= ctrl.rcon_en ? rcon : 8'h00;  // rcon hits byte 0 only
      sub_q  <= ctrl.sub;
    end else if (ctrl.shift) begin
      t_sr   <= {t_sr[23:0], 8'h00};
      b_sr   <= {b_sr[23:0], 8'h00};
      r_byte <= 8'h00;
      res_sr <= {res_sr[23:0], byte_out};
    end
  end

  assign word_out = res_sr;

endmodule

>>> rtl/core/aes_key_expansion.sv
// aes_key_expansion: lazy AES-128/192/256 key schedule with on-chip word store.
// Top level; instantiates ake_byte_lane and holds the schedule memory.
// Depends on ake_pkg.
//
//   channel   signals                              direction  handshake
//   ------------------------------------------------------------------------
//   request   start, opcode, word_index, key_word  in         start & !busy
//   result    done, round_word, status             out        done, 1 cycle
//   config    cfg_we, cfg_wdata (Nk)               in         cfg_we
//
// Sequencing: a load or a failed read raises no busy; its result strobes in the
// next cycle. A read of a word already in the store is busy in ST_RD_OUT and
// strobes from the done register set there. Each word that must be expanded
// goes through a two-port store read, a lane load, four byte steps through the
// lane, a store write; the result strobes in the cycle after the last write.
// Reset drops the key and count, sets rcon to 1 and Nk to 4; the store is not
// cleared. Results cannot be stalled: done is held for exactly one cycle.
module aes_key_expansion #(
  parameter int MAX_WORDS = ake_pkg::MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [5:0]  word_index,
  input  logic [31:0] key_word,
  output logic        done,
  output logic [31:0] round_word,
  output logic [1:0]  status
);
  import ake_pkg::*;

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int EW = (CW > 7) ? CW : 7;   // common width for index compares

  // schedule store, two registered read ports, one write port
  logic [31:0] mem [MAX_WORDS];
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;
  logic [31:0]   rd_a;
  logic [31:0]   rd_b;

  // control state
  state_t      state;
  state_t      state_next;
  logic [3:0]  nk;
  logic        key_present;
  logic [CW-1:0] count;      // expanded_count; also k during expansion
  logic [2:0]  pos;          // count mod Nk
  logic [7:0]  rcon;
  logic [5:0]  idx_q;
  logic [1:0]  byte_cnt;

  logic        accept;
  logic        load_bad;
  logic        load_last;
  logic        rd_range;
  logic        rd_hit;
  logic        pos_zero;
  logic        pos_last;
  logic        sub_only;
  logic        at_target;
  logic [7:0]  rcon_use;
  logic [3:0]  nk_sat;
  lane_ctrl_t  lane_ctrl;
  logic [31:0] lane_word;

  assign accept    = start && !busy;
  assign load_bad  = word_index >= 6'(nk);
  assign load_last = word_index == (6'(nk) - 6'd1);
  assign rd_range  = EW'(word_index) >= EW'(MAX_WORDS);
  assign rd_hit    = EW'(word_index) < EW'(count);
  assign pos_zero  = pos == 3'd0;
  assign pos_last  = {1'b0, pos} == (nk - 4'd1);
  assign sub_only  = (nk > 4'd6) && (pos == 3'd4);
  assign at_target = EW'(count) == EW'(idx_q);
  // doubled before every round but the first
  assign rcon_use  = (pos_zero && (count != CW'(nk))) ? gf_double(rcon) : rcon;
  assign nk_sat    = (cfg_wdata < NK_MIN) ? NK_MIN :
                     (cfg_wdata > NK_MAX) ? NK_MAX : cfg_wdata;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_READ && !rd_range && key_present) begin
          state_next = rd_hit ? ST_RD_OUT : ST_EXP_RD;
        end
      end
      ST_RD_OUT:    state_next = ST_IDLE;
      ST_EXP_RD:    state_next = ST_EXP_LOAD;
      ST_EXP_LOAD:  state_next = ST_EXP_SHIFT;
      ST_EXP_SHIFT: begin
        if (byte_cnt == 2'd3) begin
          state_next = ST_EXP_WR;
        end
      end
      ST_EXP_WR:    state_next = at_target ? ST_IDLE : ST_EXP_RD;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs of the FSM: busy, store ports, lane control
  always_comb begin
    busy      = state != ST_IDLE;
    addr_a    = (state == ST_IDLE) ? AW'(word_index) : AW'(count - CW'(1));
    addr_b    = AW'(count - CW'(nk));
    wr_en     = 1'b0;
    wr_addr   = AW'(count);
    wr_data   = lane_word;
    lane_ctrl = '0;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_LOAD && !load_bad) begin
          wr_en   = 1'b1;
          wr_addr = AW'(word_index);
          wr_data = key_word;
        end
      end
      ST_EXP_LOAD: begin
        lane_ctrl.load    = 1'b1;
        lane_ctrl.rot     = pos_zero;
        lane_ctrl.sub     = pos_zero || sub_only;
        lane_ctrl.rcon_en = pos_zero;
      end
      ST_EXP_SHIFT: lane_ctrl.shift = 1'b1;
      ST_EXP_WR:    wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  ake_byte_lane u_lane (
    .clk       (clk),
    .ctrl      (lane_ctrl),
    .prev_word (rd_a),
    .back_word (rd_b),
    .rcon      (rcon_use),
    .word_out  (lane_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      nk          <= NK_RESET;
      key_present <= 1'b0;
      count       <= '0;
      pos         <= '0;
      rcon        <= 8'h01;
      byte_cnt    <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_we) begin
        // new key length drops the key
        nk          <= nk_sat;
        key_present <= 1'b0;
        count       <= '0;
        pos         <= '0;
        rcon        <= 8'h01;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            idx_q <= word_index;
            if (opcode == OP_LOAD) begin
              done       <= 1'b1;
              round_word <= '0;
              if (load_bad) begin
                status <= STAT_LOADIDX;
              end else begin
                status <= STAT_OK;
                if (load_last) begin
                  key_present <= 1'b1;
                  count       <= CW'(nk);
                  pos         <= '0;
                  rcon        <= 8'h01;
                end else begin
                  key_present <= 1'b0;
                end
              end
            end else if (rd_range) begin
              done       <= 1'b1;
              round_word <= '0;
              status     <= STAT_RANGE;
            end else if (!key_present) begin
              done       <= 1'b1;
              round_word <= '0;
              status     <= STAT_NOKEY;
            end
          end
        end
        ST_RD_OUT: begin
          done       <= 1'b1;
          round_word <= rd_a;
          status     <= STAT_OK;
        end
        ST_EXP_LOAD: begin
          rcon     <= rcon_use;
          byte_cnt <= '0;
        end
        ST_EXP_SHIFT: byte_cnt <= byte_cnt + 2'd1;
        ST_EXP_WR: begin
          count <= count + CW'(1);
          pos   <= pos_last ? 3'd0 : pos + 3'd1;
          if (at_target) begin
            done       <= 1'b1;
            round_word <= lane_word;
            status     <= STAT_OK;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
